[hw/rtl/modem_escape_guard_detector_top_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros for the escape guard detector
// ---------------------------------------------------------------------------
`ifndef MODEM_ESCAPE_GUARD_DETECTOR_TOP_MACROS_SVH
`define MODEM_ESCAPE_GUARD_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MEGD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define MEGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[hw/rtl/megd_pkg.sv]
// ---------------------------------------------------------------------------
// megd_pkg
// shared types and constants of the escape guard detector
// ---------------------------------------------------------------------------
package megd_pkg;

  localparam int CHAR_W     = 8;
  localparam int TIME_W     = 32;
  localparam int GUARD_W    = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GUARD_TIME  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_CHAR = 2'd1;

  // reset values of the registers
  localparam logic [GUARD_W-1:0] GUARD_TIME_RESET  = 8'd50;
  localparam logic [CHAR_W-1:0]  ESCAPE_CHAR_RESET = 8'd43;

  // item modes
  localparam logic MODE_CHAR       = 1'b0;
  localparam logic MODE_TIME_CHECK = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [TIME_W-1:0] time_now;
  } item_t;

  typedef struct packed {
    logic escape_found;
    logic awaiting_silence;
  } result_t;

  typedef struct packed {
    logic [GUARD_W-1:0] guard_time;
    logic [CHAR_W-1:0]  escape_char;
  } cfg_t;

endpackage

[hw/rtl/megd_cfg.sv]
// ---------------------------------------------------------------------------
// megd_cfg
// configuration registers: guard time and escape character
// ---------------------------------------------------------------------------
module megd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [megd_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [megd_pkg::CFG_DATA_W-1:0]     wr_data,
  output megd_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guard_time  <= megd_pkg::GUARD_TIME_RESET;
      cfg.escape_char <= megd_pkg::ESCAPE_CHAR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        megd_pkg::REG_GUARD_TIME:  cfg.guard_time  <= wr_data;
        megd_pkg::REG_ESCAPE_CHAR: cfg.escape_char <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/megd_engine.sv]
// ---------------------------------------------------------------------------
// megd_engine
// escape sequence state and its single-pass update for one request
// ---------------------------------------------------------------------------
module megd_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  megd_pkg::item_t  item,
  input  megd_pkg::cfg_t   cfg,
  output megd_pkg::result_t result_next
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;
  localparam logic [1:0] PH_THREE = 2'd3;

  localparam int TW = megd_pkg::TIME_W;

  logic [1:0]    phase, phase_next;
  logic [TW-1:0] first_escape_time, first_escape_time_next;
  logic [TW-1:0] deadline_time, deadline_time_next;
  logic [TW-1:0] previous_char_time, previous_char_time_next;
  logic          silence_armed, silence_armed_next;

  logic [TW-1:0] guard;
  logic [TW-1:0] d_window, d_prev, d_deadline;
  logic          esc, in_window, start_ok, reached, check_start, found;

  // guard in 10 ms ticks is twice the 20 ms register value
  assign guard = TW'({cfg.guard_time, 1'b0});

  assign esc        = (item.char_code == cfg.escape_char);
  assign d_window   = item.time_now - (first_escape_time + guard);
  assign d_prev     = item.time_now - (previous_char_time + guard);
  assign d_deadline = item.time_now - deadline_time;
  // serial time compares on the wrapped difference
  assign in_window  = !((d_window != '0) && !d_window[TW-1]);
  assign start_ok   = (d_prev != '0) && !d_prev[TW-1];
  assign reached    = !d_deadline[TW-1];

  always_comb begin
    phase_next              = phase;
    first_escape_time_next  = first_escape_time;
    deadline_time_next      = deadline_time;
    previous_char_time_next = previous_char_time;
    silence_armed_next      = silence_armed;
    check_start             = 1'b0;
    found                   = 1'b0;
    if (item.mode == megd_pkg::MODE_TIME_CHECK) begin
      if (silence_armed && reached) begin
        silence_armed_next = 1'b0;
        phase_next         = PH_IDLE;
        found              = 1'b1;
      end
    end else begin
      case (phase)
        PH_ONE: begin
          phase_next = (esc && in_window) ? PH_TWO : PH_IDLE;
        end
        PH_TWO: begin
          if (esc && in_window) begin
            silence_armed_next = 1'b1;
            deadline_time_next = item.time_now + guard;
            phase_next         = PH_THREE;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_THREE: begin
          // a late character cancels the deadline and is judged as in idle
          silence_armed_next = 1'b0;
          phase_next         = PH_IDLE;
          check_start        = 1'b1;
        end
        default: begin
          phase_next  = PH_IDLE;
          check_start = 1'b1;
        end
      endcase
      if (check_start && esc && start_ok) begin
        first_escape_time_next = item.time_now;
        phase_next             = PH_ONE;
      end
      previous_char_time_next = item.time_now;
    end
  end

  assign result_next.escape_found     = found;
  assign result_next.awaiting_silence = silence_armed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      first_escape_time  <= '0;
      deadline_time      <= '0;
      previous_char_time <= '0;
      silence_armed      <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      first_escape_time  <= first_escape_time_next;
      deadline_time      <= deadline_time_next;
      previous_char_time <= previous_char_time_next;
      silence_armed      <= silence_armed_next;
    end
  end

endmodule

[hw/rtl/modem_escape_guard_detector_top.sv]
// ---------------------------------------------------------------------------
// modem_escape_guard_detector_top
// guard-time escape sequence detector for a modem character stream
// ---------------------------------------------------------------------------
// each request is a received character or a bare time check; every request
// yields exactly one result, registered when the result side is free. one
// request is taken per cycle unless stalled: the input register feeds a
// single pass of compares and adds on 32-bit times that updates the
// sequence state and loads the result register, so a new request can enter
// while the previous result still waits. the input register stalls only
// when the result register is full and not being taken. configuration
// writes are always accepted and take effect on the next cycle.
`include "modem_escape_guard_detector_top_macros.svh"

module modem_escape_guard_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [megd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [megd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                item_valid,
  output logic                                item_ready,
  input  megd_pkg::item_t                     item,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output megd_pkg::result_t                   result
);

  megd_pkg::cfg_t    cfg;
  megd_pkg::item_t   item_q;
  megd_pkg::result_t result_next;
  logic              item_q_valid;
  logic              advance;

  // registers take every write, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  megd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the held request moves on whenever the result register can take it
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // sequence state and its update
  megd_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item_q),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // a processed request always lands in the result register
  `MEGD_ASSERT_NEXT(a_advance_fills_result, clk, rst, advance, result_valid)
  // a held request that cannot move stays held
  `MEGD_ASSERT_NEXT(a_stall_keeps_item, clk, rst, item_q_valid && !advance, item_q_valid)
  // reporting the escape always disarms the deadline
  `MEGD_ASSERT_IMPL(a_found_disarms, clk, rst, result_valid && result.escape_found,
                    !result.awaiting_silence)

endmodule
